// ----- sv/dhts_pkg.sv -----
// Shared types and constants for the direct hash table store.
// Depends on nothing; imported by every other file of the block.
package dhts_pkg;

  localparam int HASH_W = 64;
  localparam int CFG_W = 9;
  localparam int CHAR_W = 8;
  localparam int OPCODE_W = 2;
  localparam int SLOT_INDEX_W = 8;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 9'd256;
  localparam logic [CHAR_W:0] CHAR_OFFSET = 9'd96;
  localparam logic [4:0] WEIGHT_BASE = 5'd26;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_GET = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIV_GO,
    S_DIV,
    S_MEM,
    S_OUT
  } state_t;

endpackage

// ----- sv/direct_hash_table_store.sv -----
// Direct-mapped hash table with a running polynomial key hash; top level.
// Depends on dhts_pkg and dhts_mod_unit.
//
//   channel  signals                                         direction
//   in       in_valid/in_ready, opcode, key_char, has_char,  into block
//            last_char, entry_data
//   out      out_valid/out_ready, found, read_data,          out of block
//            slot_index
//   cfg      cfg_wr_en, cfg_wr_data (table_size)             into block
//
// A counted character is accepted, multiplied and accumulated; an uncounted
// one that is not last is only accepted. A last item then passes the
// bit-serial remainder unit (one hash bit per cycle) and table access.
// After reset a clearing pass over every slot resets the valid bits;
// in_ready stays low meanwhile. A waiting result holds only the final stage.
module direct_hash_table_store import dhts_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OPCODE_W-1:0]     opcode,
  input  logic [CHAR_W-1:0]       key_char,
  input  logic                    has_char,
  input  logic                    last_char,
  input  logic [DATA_WIDTH-1:0]   entry_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [DATA_WIDTH-1:0]   read_data,
  output logic [SLOT_INDEX_W-1:0] slot_index,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;
  localparam int PROD_W = HASH_W + CHAR_W + 2;

  state_t state, state_next;

  logic [CFG_W-1:0]      table_size;
  logic [HASH_W-1:0]     hash_accum;
  logic [HASH_W-1:0]     char_weight;
  logic [HASH_W-1:0]     prod;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     clr_addr;

  logic [OPCODE_W-1:0]   op_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  has_q;
  logic                  last_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [DATA_WIDTH-1:0] data_mem [TABLE_DEPTH];
  logic                  valid_mem [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] data_rd;
  logic                  valid_rd;

  logic                  div_start;
  logic                  div_done;
  logic [SLOT_W-1:0]     div_rem;
  logic [CMP_W-1:0]      size_ext;
  logic [SLOT_W:0]       used_slots;
  logic signed [CHAR_W:0] char_term;
  logic signed [PROD_W-1:0] prod_full;
  logic                  dm_we;
  logic                  vm_we;
  logic                  vm_wdata;
  logic [SLOT_W-1:0]     vm_addr;
  logic                  out_load;

  assign size_ext = CMP_W'(table_size);

  always_comb begin
    if (size_ext == '0) begin
      used_slots = (SLOT_W + 1)'(1);
    end else if (size_ext > CMP_W'(TABLE_DEPTH)) begin
      used_slots = (SLOT_W + 1)'(TABLE_DEPTH);
    end else begin
      used_slots = size_ext[SLOT_W:0];
    end
  end

  assign char_term = $signed({char_q[CHAR_W-1], char_q}) - $signed(CHAR_OFFSET);
  assign prod_full = $signed({1'b0, char_weight}) * char_term;

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    div_start = 1'b0;
    dm_we = 1'b0;
    vm_we = 1'b0;
    vm_wdata = 1'b0;
    vm_addr = slot;
    out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        vm_we = 1'b1;
        vm_addr = clr_addr;
        if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_char && (key_char != '0)) begin
            state_next = S_MUL;
          end else if (last_char) begin
            state_next = S_DIV_GO;
          end
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = last_q ? S_DIV_GO : S_IDLE;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        dm_we = (op_q == OP_INSERT);
        vm_we = (op_q == OP_INSERT) || (op_q == OP_DELETE);
        vm_wdata = (op_q == OP_INSERT);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      table_size <= TABLE_SIZE_RESET;
      hash_accum <= '0;
      char_weight <= HASH_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (state == S_MUL) begin
        char_weight <= HASH_W'(char_weight * WEIGHT_BASE);
      end
      if (state == S_ACC) begin
        hash_accum <= hash_accum + prod;
      end
      if (state == S_DIV && div_done) begin
        hash_accum <= '0;
        char_weight <= HASH_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= opcode;
      char_q <= key_char;
      has_q <= has_char;
      last_q <= last_char;
      data_q <= entry_data;
    end
    if (state == S_MUL) begin
      prod <= prod_full[HASH_W-1:0];
    end
    if (state == S_DIV && div_done) begin
      slot <= div_rem;
    end
    if (out_load) begin
      found <= (op_q == OP_GET) && valid_rd;
      read_data <= ((op_q == OP_GET) && valid_rd) ? data_rd : '0;
      slot_index <= SLOT_INDEX_W'(slot);
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[slot] <= data_q;
    end
    data_rd <= data_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      valid_mem[vm_addr] <= vm_wdata;
    end
    valid_rd <= valid_mem[slot];
  end

  dhts_mod_unit #(
    .SLOT_W(SLOT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hash_accum),
    .divisor  (used_slots),
    .done     (div_done),
    .remainder(div_rem)
  );

endmodule

// ----- sv/dhts_mod_unit.sv -----
// Bit-serial remainder unit: reduces the 64-bit hash modulo the slot count,
// one dividend bit per cycle. Depends on dhts_pkg.
module dhts_mod_unit import dhts_pkg::*; #(
  parameter int SLOT_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [SLOT_W:0]   divisor,
  output logic              done,
  output logic [SLOT_W-1:0] remainder
);

  localparam int CNT_W = $clog2(HASH_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [HASH_W-1:0] dvd;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W:0]   dvs;
  logic [SLOT_W:0]   trial;
  logic [SLOT_W:0]   diff;
  logic [SLOT_W-1:0] rem_next;

  assign trial = {rem, dvd[HASH_W-1]};
  assign diff = trial - dvs;
  assign rem_next = (trial >= dvs) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

// ----- sv/dhts_checker.sv -----
// Port-level checks for the direct hash table store, bound to the top level.
// Depends on dhts_pkg and direct_hash_table_store.
module dhts_checker import dhts_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [CHAR_W-1:0]       key_char,
  input logic                    has_char,
  input logic                    last_char,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    found,
  input logic [DATA_WIDTH-1:0]   read_data,
  input logic [SLOT_INDEX_W-1:0] slot_index
);

  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("block ready or result shown right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (last_char || (has_char && key_char != '0)) |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> read_data == '0)
    else $error("read_data nonzero without found");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_data)
      && $stable(slot_index))
    else $error("stalled result changed or dropped");

endmodule

bind direct_hash_table_store dhts_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dhts_checker (.*);
